>>> sv/lbtm_pkg.sv
// Shared types, constants and helpers for the logit bias and token mask unit.
package lbtm_pkg;

   localparam int VOCAB_DEPTH = 32768;
   localparam int LIST_CAP    = 512;

   localparam int IDX_W   = $clog2(VOCAB_DEPTH);
   localparam int SIZE_W  = $clog2(VOCAB_DEPTH + 1);
   localparam int CFG_W   = 16;
   localparam int CMP_W   = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;
   localparam int CNT_W   = $clog2(LIST_CAP + 1);
   localparam int LIST_AW = (LIST_CAP > 1) ? $clog2(LIST_CAP) : 1;
   localparam int DATA_W  = 32;

   localparam logic [CFG_W-1:0]         RESET_SIZE = 16'h8000;
   localparam logic [DATA_W-1:0]        NEG_INF    = 32'h8000_0000;
   localparam logic [DATA_W-1:0]        MAX_FIN    = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0]        MIN_FIN    = 32'h8000_0001;
   localparam logic signed [DATA_W:0]   SUM_HI     = 33'sd2147483647;
   localparam logic signed [DATA_W:0]   SUM_LO     = -33'sd2147483647;

   typedef enum logic [2:0] {
      OP_BEGIN = 3'd0,
      OP_WRITE = 3'd1,
      OP_ALLOW = 3'd2,
      OP_BIAS  = 3'd3,
      OP_STOP  = 3'd4,
      OP_READ  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic              mark;
      logic [DATA_W-1:0] logit;
   } entry_type;

   typedef struct packed {
      logic [2:0]        op;
      logic              in_range;
      logic [DATA_W-1:0] value;
      logic              allow_mode;
      logic              stop_active;
      logic              list_full;
   } cmd_type;

   typedef struct packed {
      logic              wr_en;
      entry_type         wr_data;
      logic              list_push;
      logic [DATA_W-1:0] result;
      status_type        status;
   } upd_type;

   // row size register limited to 1..VOCAB_DEPTH
   function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
      logic [CMP_W-1:0] w;
      w = CMP_W'(v);
      if (w == '0) begin
         w = CMP_W'(1);
      end else if (w > CMP_W'(VOCAB_DEPTH)) begin
         w = CMP_W'(VOCAB_DEPTH);
      end
      return SIZE_W'(w);
   endfunction

endpackage

>>> sv/lbtm_if.sv
// Channel interfaces: request, response and configuration write.
interface lbtm_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic signed [31:0] token_id;
   logic signed [31:0] value;
   logic [30:0]        position;
   logic [30:0]        min_length;

   modport source(output valid, op, token_id, value, position, min_length, input ready);
   modport sink(input valid, op, token_id, value, position, min_length, output ready);
endinterface

interface lbtm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [1:0]         status;

   modport source(output valid, result_value, status, input ready);
   modport sink(input valid, result_value, status, output ready);
endinterface

interface lbtm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

>>> sv/logit_bias_and_token_mask_unit.sv
// Top level: logit row store with allow marks, bias and stop masking.
//
//   channel  dir  handshake        payload
//   req_ch   in   valid / ready    op, token_id, value, position, min_length
//   rsp_ch   out  valid / ready    result_value, status
//   csr_ch   in   valid / ready=1  data (row size)
//
// Each item is accepted with a store read, then modified and written back.
// A begin row item then undoes the mark of each accepted allow item of the row just ended,
// working from the undo list (list read, entry read, entry write).
// After reset a clearing pass writes all VOCAB_DEPTH (32768) entries, one a cycle.
// A stalled response holds the next item in its write-back step.
module logit_bias_and_token_mask_unit (
   input  logic       clock,
   input  logic       reset,
   lbtm_req_if.sink   req_ch,
   lbtm_rsp_if.source rsp_ch,
   lbtm_csr_if.sink   csr_ch
);
   import lbtm_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_CLR_LIST,
      S_CLR_RD,
      S_CLR_WR
   } state_type;

   state_type         state_ff;
   logic [IDX_W-1:0]  init_cnt_ff;
   logic [SIZE_W-1:0] eff_ff;
   logic              allow_mode_ff;
   logic              stop_active_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  sweep_ff;
   logic [CNT_W-1:0]  sweep_end_ff;
   logic [2:0]        op_ff;
   logic              in_range_ff;
   logic [DATA_W-1:0] value_ff;
   logic [IDX_W-1:0]  addr_ff;
   logic              stop_cmp_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_result_ff;
   status_type        rsp_status_ff;

   logic              accept;
   logic              fire;
   logic              id_in_range;
   logic [SIZE_W-1:0] lim;
   logic [IDX_W-1:0]  clamp_idx;
   cmd_type           cmd;
   upd_type           upd;

   logic              st_wr_en;
   logic [IDX_W-1:0]  st_wr_addr;
   entry_type         st_wr_data;
   logic              st_rd_en;
   logic [IDX_W-1:0]  st_rd_addr;
   entry_type         st_rd_data;
   logic [IDX_W-1:0]  list_rd_data;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign accept       = req_ch.valid && req_ch.ready;
   assign fire         = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_value = rsp_result_ff;
   assign rsp_ch.status       = rsp_status_ff;

   // allow ids clamp into the row; other ops use the id when in range
   always_comb begin
      id_in_range = !req_ch.token_id[31] && (req_ch.token_id[30:0] < 31'(eff_ff));
      lim         = eff_ff - SIZE_W'(1);
      if (req_ch.token_id[31]) begin
         clamp_idx = '0;
      end else if (id_in_range) begin
         clamp_idx = req_ch.token_id[IDX_W-1:0];
      end else begin
         clamp_idx = lim[IDX_W-1:0];
      end
   end

   always_comb begin
      cmd.op          = op_ff;
      cmd.in_range    = in_range_ff;
      cmd.value       = value_ff;
      cmd.allow_mode  = allow_mode_ff;
      cmd.stop_active = stop_active_ff;
      cmd.list_full   = (count_ff >= CNT_W'(LIST_CAP));
   end

   lbtm_update u_update (
      .cmd       (cmd),
      .old_entry (st_rd_data),
      .upd       (upd)
   );

   always_comb begin
      st_rd_en   = accept || (state_ff == S_CLR_RD);
      st_rd_addr = (state_ff == S_CLR_RD) ? list_rd_data : clamp_idx;
      unique case (state_ff)
         S_INIT: begin
            st_wr_en   = 1'b1;
            st_wr_addr = init_cnt_ff;
            st_wr_data = '0;
         end
         S_EXEC: begin
            st_wr_en   = fire && upd.wr_en;
            st_wr_addr = addr_ff;
            st_wr_data = upd.wr_data;
         end
         S_CLR_WR: begin
            st_wr_en         = 1'b1;
            st_wr_addr       = list_rd_data;
            st_wr_data.mark  = 1'b0;
            st_wr_data.logit = st_rd_data.logit;
         end
         default: begin
            st_wr_en   = 1'b0;
            st_wr_addr = addr_ff;
            st_wr_data = upd.wr_data;
         end
      endcase
   end

   lbtm_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (VOCAB_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // undo list of marked entries for the current row
   lbtm_ram #(
      .WIDTH (IDX_W),
      .DEPTH (LIST_CAP)
   ) u_list (
      .clock   (clock),
      .wr_en   (fire && upd.list_push),
      .wr_addr (count_ff[LIST_AW-1:0]),
      .wr_data (addr_ff),
      .rd_en   (state_ff == S_CLR_LIST),
      .rd_addr (sweep_ff[LIST_AW-1:0]),
      .rd_data (list_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         init_cnt_ff    <= '0;
         eff_ff         <= eff_size(RESET_SIZE);
         allow_mode_ff  <= 1'b0;
         stop_active_ff <= 1'b0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            eff_ff <= eff_size(csr_ch.data);
         end
         if (fire) begin
            rsp_valid_ff  <= 1'b1;
            rsp_result_ff <= upd.result;
            rsp_status_ff <= upd.status;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT: begin
               init_cnt_ff <= init_cnt_ff + IDX_W'(1);
               if (init_cnt_ff == IDX_W'(VOCAB_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_ch.valid) begin
                  op_ff       <= req_ch.op;
                  in_range_ff <= id_in_range;
                  value_ff    <= req_ch.value;
                  addr_ff     <= clamp_idx;
                  stop_cmp_ff <= (req_ch.position < req_ch.min_length);
                  state_ff    <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (fire) begin
                  if (op_ff == OP_BEGIN) begin
                     allow_mode_ff  <= 1'b0;
                     stop_active_ff <= stop_cmp_ff;
                     count_ff       <= '0;
                     sweep_ff       <= '0;
                     sweep_end_ff   <= count_ff;
                     state_ff       <= (count_ff != '0) ? S_CLR_LIST : S_IDLE;
                  end else begin
                     if (upd.list_push) begin
                        count_ff      <= count_ff + CNT_W'(1);
                        allow_mode_ff <= 1'b1;
                     end
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_CLR_LIST: begin
               state_ff <= S_CLR_RD;
            end
            S_CLR_RD: begin
               state_ff <= S_CLR_WR;
            end
            S_CLR_WR: begin
               sweep_ff <= sweep_ff + CNT_W'(1);
               if ((sweep_ff + CNT_W'(1)) == sweep_end_ff) begin
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_CLR_LIST;
               end
            end
            default: begin
               state_ff <= S_INIT;
            end
         endcase
      end
   end

endmodule

>>> sv/lbtm_ram.sv
// Generic simple dual-port RAM, registered read data.
module lbtm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/lbtm_update.sv
// Entry update: per-op new entry, saturating bias add, masked read result.
module lbtm_update (
   input  lbtm_pkg::cmd_type   cmd,
   input  lbtm_pkg::entry_type old_entry,
   output lbtm_pkg::upd_type   upd
);
   import lbtm_pkg::*;

   logic signed [DATA_W:0] sum;
   logic [DATA_W-1:0]      biased;
   logic                   masked;

   always_comb begin
      sum = $signed({old_entry.logit[DATA_W-1], old_entry.logit})
          + $signed({cmd.value[DATA_W-1], cmd.value});
      if (old_entry.logit == NEG_INF || cmd.value == NEG_INF) begin
         biased = NEG_INF;
      end else if (sum > SUM_HI) begin
         biased = MAX_FIN;
      end else if (sum < SUM_LO) begin
         biased = MIN_FIN;
      end else begin
         biased = sum[DATA_W-1:0];
      end
   end

   assign masked = cmd.allow_mode && !old_entry.mark;

   always_comb begin
      upd.wr_en     = 1'b0;
      upd.wr_data   = old_entry;
      upd.list_push = 1'b0;
      upd.result    = '0;
      upd.status    = ST_DONE;
      unique case (cmd.op)
         OP_WRITE: begin
            if (cmd.in_range) begin
               upd.wr_en         = 1'b1;
               upd.wr_data.logit = cmd.value;
            end else begin
               upd.status = ST_RANGE;
            end
         end
         OP_ALLOW: begin
            if (cmd.list_full) begin
               upd.status = ST_FULL;
            end else begin
               upd.wr_en        = 1'b1;
               upd.wr_data.mark = 1'b1;
               upd.list_push    = 1'b1;
            end
         end
         OP_BIAS: begin
            if (!cmd.in_range) begin
               upd.status = ST_RANGE;
            end else if (!masked) begin
               upd.wr_en         = 1'b1;
               upd.wr_data.logit = biased;
            end
         end
         OP_STOP: begin
            if (!cmd.in_range) begin
               upd.status = ST_RANGE;
            end else if (cmd.stop_active) begin
               upd.wr_en         = 1'b1;
               upd.wr_data.logit = NEG_INF;
            end
         end
         OP_READ: begin
            if (!cmd.in_range) begin
               upd.status = ST_RANGE;
            end else begin
               upd.result = masked ? NEG_INF : old_entry.logit;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

>>> sv/lbtm_checker.sv
// Port-level checks for the logit bias and token mask unit, with bind.
module lbtm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result_value,
   input logic [1:0]  rsp_status
);

   // clearing pass keeps both sides quiet right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or response valid right after reset");

   // one word in flight
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous word still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_result_value) && $stable(rsp_status))
      else $error("response word changed while stalled");

endmodule

bind logit_bias_and_token_mask_unit lbtm_checker u_lbtm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.result_value),
   .rsp_status       (rsp_ch.status)
);

>>> tb/logit_row_monitor.sv
// Watches the request, response and size channels, models the logit row and checks responses.
module logit_row_monitor (
   input  logic clock,
   input  logic reset,
   lbtm_req_if  req_ch,
   lbtm_rsp_if  rsp_ch,
   lbtm_csr_if  csr_ch,
   output int   fail_count,
   output int   pending,
   output int   row_size
);
   timeunit 1ns;
   timeprecision 1ps;
   import lbtm_pkg::*;

   typedef struct {
      logic [DATA_W-1:0] value;
      status_type        status;
   } row_resp_type;

   logic [DATA_W-1:0] row_logits [VOCAB_DEPTH];
   bit                row_marks [VOCAB_DEPTH];
   int                marked_ids [$];
   bit                allow_on;
   int                allow_count;
   bit                stop_on;
   row_resp_type      due_responses [$];

   function automatic logic [DATA_W-1:0] add_bias(logic [DATA_W-1:0] a,
                                                 logic [DATA_W-1:0] b);
      logic signed [DATA_W:0] sum;
      if (a == NEG_INF || b == NEG_INF) begin
         return NEG_INF;
      end
      sum = $signed({a[DATA_W-1], a}) + $signed({b[DATA_W-1], b});
      if (sum > SUM_HI) begin
         return MAX_FIN;
      end else if (sum < SUM_LO) begin
         return MIN_FIN;
      end
      return sum[DATA_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic apply_row_op(output row_resp_type resp);
      int id;
      bit in_range;
      int slot;
      id          = req_ch.token_id;
      in_range    = id >= 0 && id < row_size;
      resp.value  = '0;
      resp.status = ST_DONE;
      case (req_ch.op)
         OP_BEGIN: begin
            foreach (marked_ids[i]) row_marks[marked_ids[i]] = 1'b0;
            marked_ids.delete();
            allow_on    = 1'b0;
            allow_count = 0;
            stop_on     = req_ch.position < req_ch.min_length;
         end
         OP_WRITE: begin
            if (in_range) begin
               row_logits[id] = req_ch.value;
            end else begin
               resp.status = ST_RANGE;
            end
         end
         OP_ALLOW: begin
            if (allow_count >= LIST_CAP) begin
               resp.status = ST_FULL;
            end else begin
               // ids are clamped into the row, not rejected
               slot = (id < 0) ? 0 : ((id >= row_size) ? row_size - 1 : id);
               if (!row_marks[slot]) begin
                  row_marks[slot] = 1'b1;
                  marked_ids.push_back(slot);
               end
               allow_count++;
               allow_on = 1'b1;
            end
         end
         OP_BIAS: begin
            if (!in_range) begin
               resp.status = ST_RANGE;
            end else if (!(allow_on && !row_marks[id])) begin
               row_logits[id] = add_bias(row_logits[id], req_ch.value);
            end
         end
         OP_STOP: begin
            if (!in_range) begin
               resp.status = ST_RANGE;
            end else if (stop_on) begin
               row_logits[id] = NEG_INF;
            end
         end
         OP_READ: begin
            if (!in_range) begin
               resp.status = ST_RANGE;
            end else if (allow_on && !row_marks[id]) begin
               resp.value = NEG_INF;
            end else begin
               resp.value = row_logits[id];
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      row_resp_type want;
      if (reset) begin
         foreach (row_marks[i]) row_marks[i] = 1'b0;
         marked_ids.delete();
         due_responses.delete();
         allow_on    = 1'b0;
         allow_count = 0;
         stop_on     = 1'b0;
         row_size    = int'(RESET_SIZE);
         fail_count  = 0;
         pending     = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            row_size = (csr_ch.data == '0) ? 1 :
                       ((csr_ch.data > VOCAB_DEPTH) ? VOCAB_DEPTH : int'(csr_ch.data));
         end
         // response word first: it can never answer a request word taken on this edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_responses.size() == 0) begin
               report_mismatch("response word with no request outstanding");
            end else begin
               want = due_responses.pop_front();
               if (rsp_ch.result_value !== want.value) begin
                  report_mismatch($sformatf("result_value %h, expected %h",
                                            rsp_ch.result_value, want.value));
               end
               if (rsp_ch.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_ch.status, want.status));
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            apply_row_op(want);
            due_responses.push_back(want);
         end
         pending = due_responses.size();
      end
   end

endmodule

>>> tb/logit_bias_and_token_mask_unit_tb.sv
// Drives requests, size writes and response stalls into the logit row unit and gives the verdict.
module logit_bias_and_token_mask_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lbtm_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int         STALL_PCT   = 18;
   localparam int         STUCK_LIMIT = 100000;
   localparam int         PHASE_ITEMS = 8;

   typedef struct {
      logic [2:0]         op;
      logic signed [31:0] token_id;
      logic signed [31:0] value;
      logic [30:0]        position;
      logic [30:0]        min_length;
   } row_cmd_type;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending;
   int   row_size;
   int   stuck_cycles = 0;
   int   sent_count;
   bit   calm;
   bit   written [VOCAB_DEPTH];

   logic [15:0] phase_sizes [8] = '{16'd1, 16'd0, 16'd16, 16'd300,
                                    16'd65535, 16'd40000, 16'd32768, 16'd7};

   lbtm_req_if req_ch ();
   lbtm_rsp_if rsp_ch ();
   lbtm_csr_if csr_ch ();

   logit_bias_and_token_mask_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logit_row_monitor row_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending),
      .row_size   (row_size)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= calm || ($urandom_range(99) >= STALL_PCT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic row_cmd_type make_cmd(logic [2:0] op, int id, logic [31:0] val,
                                            logic [30:0] pos, logic [30:0] min_len);
      row_cmd_type cmd;
      cmd.op         = op;
      cmd.token_id   = id;
      cmd.value      = val;
      cmd.position   = pos;
      cmd.min_length = min_len;
      return cmd;
   endfunction

   function automatic int pick_id();
      int hot;
      hot = (row_size < 48) ? row_size : 48;
      case ($urandom_range(19))
         0, 1, 2: return $urandom_range(row_size - 1);
         3:       return row_size - 1;
         4:       return row_size + $urandom_range(3);
         5:       return -1 - int'($urandom_range(3));
         6:       return int'($urandom);
         default: return $urandom_range(hot - 1);
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(9))
         0:       return NEG_INF;
         1:       return MAX_FIN;
         2:       return MIN_FIN;
         3, 4, 5: return 32'($urandom_range(1 << 20)) - 32'(1 << 19);
         default: return $urandom;
      endcase
   endfunction

   function automatic row_cmd_type random_cmd(logic [2:0] op);
      return make_cmd(op, pick_id(), pick_value(), 31'($urandom), 31'($urandom));
   endfunction

   task automatic issue(input row_cmd_type cmd);
      bit in_range;
      in_range = cmd.token_id >= 0 && cmd.token_id < row_size;
      // never bias or read an entry that holds nothing yet: write it instead
      if ((cmd.op == OP_BIAS || cmd.op == OP_READ) && in_range && !written[cmd.token_id]) begin
         cmd.op = OP_WRITE;
      end
      if (cmd.op == OP_WRITE && in_range) begin
         written[cmd.token_id] = 1'b1;
      end
      @(negedge clock);
      while (!calm && $urandom_range(99) < STALL_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.op         <= cmd.op;
      req_ch.token_id   <= cmd.token_id;
      req_ch.value      <= cmd.value;
      req_ch.position   <= cmd.position;
      req_ch.min_length <= cmd.min_length;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   task automatic run_row(input int n, input int allow_pct);
      row_cmd_type cmd;
      logic [2:0]  op;
      int          pick;
      cmd = random_cmd(OP_BEGIN);
      case ($urandom_range(2))
         0: begin
            cmd.position   = 31'($urandom_range(40));
            cmd.min_length = 31'($urandom_range(40));
         end
         1:       cmd.position = cmd.min_length;
         default: ;
      endcase
      issue(cmd);
      repeat (n) begin
         pick = $urandom_range(99);
         if (pick < allow_pct) begin
            op = OP_ALLOW;
         end else begin
            pick = $urandom_range(99);
            if (pick < 25) begin
               op = OP_WRITE;
            end else if (pick < 45) begin
               op = OP_BIAS;
            end else if (pick < 55) begin
               op = OP_STOP;
            end else if (pick < 95) begin
               op = OP_READ;
            end else if (pick < 98) begin
               op = OP_SPARE_LO;
            end else begin
               op = OP_SPARE_HI;
            end
         end
         issue(random_cmd(op));
      end
   endtask

   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_size(input logic [15:0] size);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= size;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      calm              = 1'b0;
      req_ch.valid      = 1'b0;
      req_ch.op         = OP_BEGIN;
      req_ch.token_id   = '0;
      req_ch.value      = '0;
      req_ch.position   = '0;
      req_ch.min_length = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.data       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_size(RESET_SIZE);
      issue(make_cmd(OP_BEGIN, 0, 0, 31'd0, 31'h7FFF_FFFF));
      issue(make_cmd(OP_WRITE, 0, MAX_FIN, 31'd0, 31'd0));
      issue(make_cmd(OP_BIAS, 0, 32'd1, 31'd0, 31'd0));
      issue(make_cmd(OP_READ, 0, 0, 31'd0, 31'd0));
      issue(make_cmd(OP_WRITE, VOCAB_DEPTH - 1, MIN_FIN, 31'd0, 31'd0));
      issue(make_cmd(OP_BIAS, VOCAB_DEPTH - 1, 32'hFFFF_FFFF, 31'd0, 31'd0));
      issue(make_cmd(OP_READ, VOCAB_DEPTH - 1, 0, 31'd0, 31'd0));
      issue(make_cmd(OP_WRITE, 2, 32'h0001_8000, 31'd0, 31'd0));
      issue(make_cmd(OP_BIAS, 2, NEG_INF, 31'd0, 31'd0));
      issue(make_cmd(OP_READ, 2, 0, 31'd0, 31'd0));
      issue(make_cmd(OP_WRITE, VOCAB_DEPTH, 32'h1234_5678, 31'd0, 31'd0));
      issue(make_cmd(OP_WRITE, 3, 32'h0000_4000, 31'd0, 31'd0));
      issue(make_cmd(OP_STOP, 3, 0, 31'd0, 31'd0));
      issue(make_cmd(OP_BIAS, 3, MAX_FIN, 31'd0, 31'd0));
      issue(make_cmd(OP_READ, 3, 0, 31'd0, 31'd0));
      issue(make_cmd(OP_SPARE_LO, 0, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
      issue(make_cmd(OP_SPARE_HI, -1, 0, 31'd0, 31'd0));
      issue(make_cmd(OP_WRITE, 5, 32'h0002_0000, 31'd0, 31'd0));
      issue(make_cmd(OP_ALLOW, -5, 0, 31'd0, 31'd0));
      issue(make_cmd(OP_ALLOW, 32'h7FFF_FFFF, 0, 31'd0, 31'd0));
      issue(make_cmd(OP_BIAS, 5, 32'h0001_0000, 31'd0, 31'd0));
      issue(make_cmd(OP_READ, 5, 0, 31'd0, 31'd0));
      issue(make_cmd(OP_READ, 0, 0, 31'd0, 31'd0));
      issue(make_cmd(OP_BEGIN, 0, 0, 31'd10, 31'd10));
      issue(make_cmd(OP_STOP, 0, 0, 31'd0, 31'd0));
      issue(make_cmd(OP_READ, 0, 0, 31'd0, 31'd0));
      settle();

      foreach (phase_sizes[p]) begin
         write_size(phase_sizes[p]);
         calm       = (p == 2);
         sent_count = 0;
         while (sent_count < PHASE_ITEMS) begin
            run_row($urandom_range(4, 12), 12);
         end
         if (p == 2) begin
            run_row(LIST_CAP + 4, 100);
         end
         settle();
      end
      calm = 1'b0;

      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> logit_bias_and_token_mask_unit.f
sv/lbtm_pkg.sv
sv/lbtm_if.sv
sv/lbtm_ram.sv
sv/lbtm_update.sv
sv/logit_bias_and_token_mask_unit.sv
sv/lbtm_checker.sv
tb/logit_row_monitor.sv
tb/logit_bias_and_token_mask_unit_tb.sv
